[src/ucp_pkg.sv]
// Package for the unicycle pose propagation block.
// Holds the transaction structs, the fixed-point constants and the arctangent table.
// Depends on nothing; used by every module under src.
package ucp_pkg;

    localparam int CordicSteps = 24;
    localparam int XyW = 34;
    localparam int ZW = 28;

    localparam logic [15:0] StepTimeReset = 16'd655;
    localparam logic [24:0] TwoPi = 25'd411775;
    localparam logic signed [20:0] Pi = 21'sd205887;
    localparam logic signed [20:0] HalfPi = 21'sd102944;
    localparam logic [24:0] ModOffset = 25'd8647275;
    localparam logic [14:0] ModRecip = 15'd20860;
    localparam logic signed [XyW-1:0] CordicGain = 34'sd652032874;

    typedef struct packed {
        logic signed [31:0] pose_x;
        logic signed [31:0] pose_y;
        logic signed [23:0] heading;
        logic signed [23:0] speed;
        logic signed [23:0] turn_rate;
        logic signed [31:0] noise_x;
        logic signed [31:0] noise_y;
        logic signed [23:0] noise_heading;
    } in_t;

    typedef struct packed {
        logic signed [31:0] next_x;
        logic signed [31:0] next_y;
        logic signed [23:0] next_heading;
        logic signed [31:0] dx_dheading;
        logic signed [31:0] dy_dheading;
    } out_t;

    typedef struct packed {
        logic signed [XyW-1:0] x;
        logic signed [XyW-1:0] y;
        logic signed [ZW-1:0]  z;
        logic                  flip;
    } cordic_t;

    function automatic logic signed [ZW-1:0] atan_entry(input int idx);
        logic signed [ZW-1:0] val;
        case (idx)
            0: val = 28'sd13176795;
            1: val = 28'sd7778716;
            2: val = 28'sd4110060;
            3: val = 28'sd2086331;
            4: val = 28'sd1047214;
            5: val = 28'sd524117;
            6: val = 28'sd262123;
            7: val = 28'sd131069;
            default: val = 28'sd1 <<< (24 - idx);
        endcase
        return val;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -34'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
        logic signed [23:0] r;
        if (v > 26'sd8388607)
            r = 24'sh7fffff;
        else if (v < -26'sd8388608)
            r = 24'sh800000;
        else
            r = v[23:0];
        return r;
    endfunction

endpackage

[src/ucp_reduce.sv]
// Angle reduction modulo two pi and quadrant fold, two register stages.
// Depends on ucp_pkg; feeds the first CORDIC stage.
module ucp_reduce (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 valid_in,
    input  logic signed [23:0]   heading,
    output logic                 valid_out,
    output ucp_pkg::cordic_t     cordic_out
);

    logic              v1_reg;
    logic [24:0]       hu_reg;
    logic [6:0]        q_reg;
    logic [24:0]       hu_next;
    logic [39:0]       prod;
    logic              v2_reg;
    ucp_pkg::cordic_t  c_reg;
    ucp_pkg::cordic_t  c_next;
    logic [25:0]       r0;
    logic [25:0]       r1;
    logic signed [20:0] m0;
    logic signed [20:0] m1;
    logic signed [20:0] m2;
    logic              flip;

    assign hu_next = 25'($signed({heading[23], heading}) + $signed(ucp_pkg::ModOffset));
    assign prod = 40'(hu_next) * 40'(ucp_pkg::ModRecip);

    always_comb
    begin
        r0 = 26'(hu_reg) - 26'(32'(q_reg) * 32'(ucp_pkg::TwoPi));
        r1 = (r0 >= 26'(ucp_pkg::TwoPi)) ? r0 - 26'(ucp_pkg::TwoPi) : r0;
        m0 = $signed(21'(r1));
        m1 = (m0 > ucp_pkg::Pi) ? m0 - $signed(21'(ucp_pkg::TwoPi)) : m0;
        flip = 1'b0;
        m2 = m1;
        if (m1 > ucp_pkg::HalfPi)
        begin
            m2 = m1 - ucp_pkg::Pi;
            flip = 1'b1;
        end
        else if (m1 < -ucp_pkg::HalfPi)
        begin
            m2 = m1 + ucp_pkg::Pi;
            flip = 1'b1;
        end
        c_next.x = ucp_pkg::CordicGain;
        c_next.y = '0;
        c_next.z = $signed({m2[19:0], 8'd0});
        c_next.flip = flip;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= valid_in;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        hu_reg <= hu_next;
        q_reg  <= prod[39:33];
        c_reg  <= c_next;
    end

    assign valid_out  = v2_reg;
    assign cordic_out = c_reg;

endmodule

[src/ucp_cordic_stage.sv]
// One rotation-mode CORDIC iteration with its output register.
// Depends on ucp_pkg for the cordic_t struct and the arctangent table.
module ucp_cordic_stage #(
    parameter int IDX = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              valid_in,
    input  ucp_pkg::cordic_t  cordic_in,
    output logic              valid_out,
    output ucp_pkg::cordic_t  cordic_out
);

    logic              valid_reg;
    ucp_pkg::cordic_t  c_reg;
    ucp_pkg::cordic_t  c_next;
    logic signed [ucp_pkg::XyW-1:0] dx;
    logic signed [ucp_pkg::XyW-1:0] dy;

    always_comb
    begin
        dx = cordic_in.y >>> IDX;
        dy = cordic_in.x >>> IDX;
        c_next.flip = cordic_in.flip;
        if (cordic_in.z >= 0)
        begin
            c_next.x = cordic_in.x - dx;
            c_next.y = cordic_in.y + dy;
            c_next.z = cordic_in.z - ucp_pkg::atan_entry(IDX);
        end
        else
        begin
            c_next.x = cordic_in.x + dx;
            c_next.y = cordic_in.y - dy;
            c_next.z = cordic_in.z + ucp_pkg::atan_entry(IDX);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        c_reg <= c_next;
    end

    assign valid_out  = valid_reg;
    assign cordic_out = c_reg;

endmodule

[src/ucp_motion.sv]
// Motion terms, pose sums and saturation in three register stages.
// Depends on ucp_pkg; takes cos and sin from the last CORDIC stage.
module ucp_motion (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              valid_in,
    input  ucp_pkg::cordic_t  cordic_in,
    input  ucp_pkg::in_t      item_in,
    input  logic [15:0]       step_time,
    output logic              valid_out,
    output ucp_pkg::out_t     result_out
);

    logic signed [16:0] dt_s;
    logic signed [34:0] cos_v;
    logic signed [34:0] sin_v;

    logic               v1_reg;
    logic signed [58:0] pc_reg;
    logic signed [58:0] ps_reg;
    logic signed [40:0] pu_reg;
    ucp_pkg::in_t       it1_reg;

    logic signed [58:0] pc_rnd;
    logic signed [58:0] ps_rnd;
    logic signed [40:0] pu_rnd;
    logic               v2_reg;
    logic signed [59:0] qc_reg;
    logic signed [59:0] qs_reg;
    logic signed [24:0] dyaw_reg;
    ucp_pkg::in_t       it2_reg;

    logic signed [59:0] qc_rnd;
    logic signed [59:0] qs_rnd;
    logic signed [29:0] dc;
    logic signed [29:0] ds;
    logic               v3_reg;
    ucp_pkg::out_t      res_reg;
    ucp_pkg::out_t      res_next;

    assign dt_s  = $signed({1'b0, step_time});
    assign cos_v = cordic_in.flip ? -35'(cordic_in.x) : 35'(cordic_in.x);
    assign sin_v = cordic_in.flip ? -35'(cordic_in.y) : 35'(cordic_in.y);

    assign pc_rnd = pc_reg + 59'sd32768;
    assign ps_rnd = ps_reg + 59'sd32768;
    assign pu_rnd = pu_reg + 41'sd32768;

    assign qc_rnd = qc_reg + 60'sd536870912;
    assign qs_rnd = qs_reg + 60'sd536870912;
    assign dc = qc_rnd[59:30];
    assign ds = qs_rnd[59:30];

    always_comb
    begin
        res_next.next_x = ucp_pkg::sat32(34'(it2_reg.pose_x) + 34'(dc) + 34'(it2_reg.noise_x));
        res_next.next_y = ucp_pkg::sat32(34'(it2_reg.pose_y) + 34'(ds) + 34'(it2_reg.noise_y));
        res_next.next_heading = ucp_pkg::sat24(26'(it2_reg.heading) + 26'(dyaw_reg)
                                               + 26'(it2_reg.noise_heading));
        res_next.dx_dheading = ucp_pkg::sat32(-34'(ds));
        res_next.dy_dheading = ucp_pkg::sat32(34'(dc));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= valid_in;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pc_reg   <= 59'(item_in.speed) * 59'(cos_v);
        ps_reg   <= 59'(item_in.speed) * 59'(sin_v);
        pu_reg   <= 41'(item_in.turn_rate) * 41'(dt_s);
        it1_reg  <= item_in;
        qc_reg   <= 60'($signed(pc_rnd[58:16])) * 60'(dt_s);
        qs_reg   <= 60'($signed(ps_rnd[58:16])) * 60'(dt_s);
        dyaw_reg <= pu_rnd[40:16];
        it2_reg  <= it1_reg;
        res_reg  <= res_next;
    end

    assign valid_out  = v3_reg;
    assign result_out = res_reg;

endmodule

[src/unicycle_pose_propagate.sv]
// Top level of the unicycle pose propagation block.
// Depends on ucp_pkg, ucp_reduce, ucp_cordic_stage and ucp_motion.
//
// A transaction is taken in every cycle that start is high; busy is never raised, so the
// block sustains one pose per clock. Each result appears on result for one cycle with
// result_valid high, after its transaction has passed through these registers in order:
// one input register loaded at the accepting edge, two for the angle reduction, 24 for
// the CORDIC iterations and three for the multiplications and saturating sums. The
// receiver cannot hold results off. The step time register resets
// to 655 and should be written only while no transaction is in flight.
module unicycle_pose_propagate (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  ucp_pkg::in_t   item,
    output logic           result_valid,
    output ucp_pkg::out_t  result,
    input  logic           cfg_wr_en,
    input  logic [15:0]    cfg_wr_data
);

    localparam int Steps = ucp_pkg::CordicSteps;

    logic [15:0]       step_time_reg;
    logic              in_valid_reg;
    ucp_pkg::in_t      item_reg;
    ucp_pkg::in_t      item_dly_reg [0:Steps+1];
    logic              red_valid;
    ucp_pkg::cordic_t  red_out;
    logic              cv [0:Steps];
    ucp_pkg::cordic_t  cs [0:Steps];

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_time_reg <= ucp_pkg::StepTimeReset;
            in_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                step_time_reg <= cfg_wr_data;
            in_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item;
        item_dly_reg[0] <= item_reg;
        for (int k = 1; k <= Steps + 1; k++)
            item_dly_reg[k] <= item_dly_reg[k-1];
    end

    ucp_reduce u_reduce (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid_in   (in_valid_reg),
        .heading    (item_reg.heading),
        .valid_out  (red_valid),
        .cordic_out (red_out)
    );

    assign cv[0] = red_valid;
    assign cs[0] = red_out;

    for (genvar g = 0; g < Steps; g++)
    begin : g_cordic
        ucp_cordic_stage #(.IDX(g)) u_stage (
            .clk        (clk),
            .rst_n      (rst_n),
            .valid_in   (cv[g]),
            .cordic_in  (cs[g]),
            .valid_out  (cv[g+1]),
            .cordic_out (cs[g+1])
        );
    end

    ucp_motion u_motion (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid_in   (cv[Steps]),
        .cordic_in  (cs[Steps]),
        .item_in    (item_dly_reg[Steps+1]),
        .step_time  (step_time_reg),
        .valid_out  (result_valid),
        .result_out (result)
    );

`ifndef ASSERT_OFF
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##30 result_valid)
        else $error("transaction did not complete after 30 cycles");
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(start && !busy, 30))
        else $error("result without a matching transaction");
    a_cordic_flow: assert property (@(posedge clk) disable iff (!rst_n)
        red_valid |-> ##24 cv[Steps])
        else $error("CORDIC pipeline lost a transaction");
`endif

endmodule
